FILE: sv/itsg_pkg.sv
// ---------------------------------------------------------------------------
// itsg_pkg: shared types and constants
// Register map codes, configuration bundle and the buffered input item used
// by the CAN frame segmenter.
// ---------------------------------------------------------------------------
package itsg_pkg;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_CAN_ID = 2'd0;
  localparam logic [1:0] REG_PAD    = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  // Reset values of the registers
  localparam logic [10:0] CAN_ID_RST = 11'd0;
  localparam logic [7:0]  PAD_RST    = 8'd0;
  localparam logic [7:0]  LIMIT_RST  = 8'd255;

  // High nibble of a consecutive-frame control byte
  localparam logic [3:0] CF_CTRL_HI = 4'h2;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [10:0] can_identifier;
    logic [7:0]  pad_byte;
    logic [7:0]  frame_limit;
  } cfg_t;

  // One buffered input item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       final_byte;
  } in_item_t;

endpackage

FILE: sv/itsg_in_stage.sv
// ---------------------------------------------------------------------------
// itsg_in_stage: input register
// Holds one accepted item for the packer; refills in the same cycle the
// packer takes the held item.
// ---------------------------------------------------------------------------
module itsg_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  itsg_pkg::in_item_t in_item,
  output logic              held_valid,
  output itsg_pkg::in_item_t held_item,
  input  logic              take
);

  assign in_ready = !held_valid || take;

  // Load a new item whenever the slot is free or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

FILE: sv/itsg_packer.sv
// ---------------------------------------------------------------------------
// itsg_packer: frame assembly and result register
// Places each byte into the open frame, inserts the consecutive-frame
// control byte, pads and emits closed frames into the output register.
// ---------------------------------------------------------------------------
module itsg_packer #(
  parameter int FRAME_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  itsg_pkg::cfg_t     cfg,
  input  logic               held_valid,
  input  itsg_pkg::in_item_t held_item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        out_id,
  output logic [63:0]        out_bytes,
  output logic [7:0]         out_index,
  output logic               out_end
);

  localparam int SW = $clog2(FRAME_BYTES + 1);
  localparam int AW = FRAME_BYTES * 8;

  // Frame state
  logic [AW-1:0] assembly_word, assembly_word_next;
  logic [SW-1:0] slot_position, slot_position_next;
  logic [7:0]    frames_sent, frames_sent_next;

  logic          limit_hit;
  logic          fin;
  logic [7:0]    b;
  logic [AW-1:0] base;
  logic [SW-1:0] pos;
  logic [SW-1:0] pos_inc;
  logic          emit;
  logic [63:0]   frame_word;

  assign take      = held_valid && (!out_valid || out_ready);
  assign fin       = held_item.final_byte;
  assign b         = held_item.payload_byte;
  assign limit_hit = frames_sent >= cfg.frame_limit;

  // Open a frame: control byte goes into slot 0 for every frame but the first
  always_comb begin
    base = assembly_word;
    pos  = slot_position;
    if (slot_position == '0) begin
      base = '0;
      if (frames_sent != 8'd0) begin
        base[7:0] = {itsg_pkg::CF_CTRL_HI, frames_sent[3:0]};
        pos       = SW'(1);
      end
    end
  end

  assign pos_inc = pos + SW'(1);
  assign emit    = (int'(pos_inc) >= FRAME_BYTES) || fin;

  // Byte lanes: kept bytes, new byte, pad, zero beyond the frame size
  always_comb begin
    frame_word         = '0;
    assembly_word_next = base;
    for (int k = 0; k < 8; k++) begin
      if (k < FRAME_BYTES) begin
        if (k < int'(pos)) begin
          frame_word[8*k +: 8] = base[8*k +: 8];
        end else if (k == int'(pos)) begin
          frame_word[8*k +: 8]         = b;
          assembly_word_next[8*k +: 8] = b;
        end else begin
          frame_word[8*k +: 8] = cfg.pad_byte;
        end
      end
    end
  end

  // State update for one taken item
  always_comb begin
    slot_position_next = slot_position;
    frames_sent_next   = frames_sent;
    if (limit_hit) begin
      if (fin) begin
        slot_position_next = '0;
        frames_sent_next   = 8'd0;
      end
    end else if (emit) begin
      slot_position_next = '0;
      frames_sent_next   = fin ? 8'd0 : frames_sent + 8'd1;
    end else begin
      slot_position_next = pos_inc;
    end
  end

  // Dropped bytes leave the open frame as it is until the message ends
  always_ff @(posedge clk) begin
    if (rst) begin
      assembly_word <= '0;
      slot_position <= '0;
      frames_sent   <= 8'd0;
    end else if (take) begin
      slot_position <= slot_position_next;
      frames_sent   <= frames_sent_next;
      if (limit_hit) begin
        if (fin) begin
          assembly_word <= '0;
        end
      end else if (emit) begin
        assembly_word <= '0;
      end else begin
        assembly_word <= assembly_word_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= !limit_hit && emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !limit_hit && emit) begin
      out_id    <= cfg.can_identifier;
      out_bytes <= frame_word;
      out_index <= frames_sent;
      out_end   <= fin;
    end
  end

endmodule

FILE: sv/iso_tp_frame_segmenter_unit.sv
// ---------------------------------------------------------------------------
// iso_tp_frame_segmenter_unit: payload byte stream to CAN frames
// One payload byte is accepted per cycle unless the output stalls; every
// byte passes the input register and the assembly logic; a frame enters
// the output register as its closing byte leaves the input register. While
// a finished frame waits the input takes at most one more byte into the
// input register, then holds off until the frame leaves. Frame 0 of a
// message holds raw bytes, later frames start with the consecutive-frame
// control byte; the frame closed by the last byte is padded. Bytes beyond
// frame_limit frames are dropped until the message ends.
// ---------------------------------------------------------------------------
module iso_tp_frame_segmenter_unit #(
  parameter int FRAME_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // payload in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] payload_byte
  input  logic        s_axis_tlast,   // final_byte
  // frames out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [10:0] frame_id, [74:11] frame_bytes,
                                      // [82:75] frame_index, [87:83] zero
  output logic        m_axis_tlast    // message_end
);

  itsg_pkg::cfg_t     cfg;
  itsg_pkg::in_item_t in_item;
  itsg_pkg::in_item_t held_item;
  logic               held_valid;
  logic               take;
  logic [10:0]        out_id;
  logic [63:0]        out_bytes;
  logic [7:0]         out_index;

  // Register file
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.can_identifier <= itsg_pkg::CAN_ID_RST;
      cfg.pad_byte       <= itsg_pkg::PAD_RST;
      cfg.frame_limit    <= itsg_pkg::LIMIT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        itsg_pkg::REG_CAN_ID: cfg.can_identifier <= pwdata[10:0];
        itsg_pkg::REG_PAD:    cfg.pad_byte       <= pwdata[7:0];
        itsg_pkg::REG_LIMIT:  cfg.frame_limit    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      itsg_pkg::REG_CAN_ID: prdata = {21'd0, cfg.can_identifier};
      itsg_pkg::REG_PAD:    prdata = {24'd0, cfg.pad_byte};
      itsg_pkg::REG_LIMIT:  prdata = {24'd0, cfg.frame_limit};
      default:              prdata = 32'd0;
    endcase
  end

  // Datapath
  assign in_item.payload_byte = s_axis_tdata;
  assign in_item.final_byte   = s_axis_tlast;

  itsg_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  itsg_packer #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_pack (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_id     (out_id),
    .out_bytes  (out_bytes),
    .out_index  (out_index),
    .out_end    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_index, out_bytes, out_id};

endmodule

FILE: sv/itsg_checker.sv
// ---------------------------------------------------------------------------
// itsg_checker: port-level checks
// Output handshake rules and frame numbering seen on the frame stream.
// ---------------------------------------------------------------------------
module itsg_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("frame valid right after reset");

  // A stalled frame stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("frame withdrawn while stalled");

  // A stalled frame keeps its contents
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("frame changed while stalled");

  // Later frames open with the consecutive-frame byte for their number
  a_ctrl_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[82:75] != 8'd0) |->
      (m_axis_tdata[18:15] == 4'h2) && (m_axis_tdata[14:11] == m_axis_tdata[78:75]))
    else $error("control byte does not match frame index");

endmodule

bind iso_tp_frame_segmenter_unit itsg_checker u_itsg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
